// ----- hdl/cfl_pkg.sv -----
// Shared types, widths and codes for the complex FIR low-pass filter.
`default_nettype none

package cfl_pkg;

    localparam int NUM_TAPS_DEFAULT = 256;
    localparam int SAMPLE_W         = 16;
    localparam int COEFF_W          = 18;
    localparam int TAP_IDX_W        = 8;
    localparam int FUNC_W           = 2;
    localparam int SHIFT_W          = 5;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd17;

    localparam int IN_FIELDS_W = 2 * SAMPLE_W + TAP_IDX_W + COEFF_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COEFF  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_COEFF  = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic signed [SAMPLE_W-1:0]  re;
        logic signed [SAMPLE_W-1:0]  im;
        logic [TAP_IDX_W-1:0]        idx;
        logic signed [COEFF_W-1:0]   coeff;
    } item_t;

endpackage

`default_nettype wire

// ----- hdl/cfl_front.sv -----
// Input side: decodes words, drops unused ones, and queues work for the MAC engine.
`default_nettype none

module cfl_front #(
    parameter int NUM_TAPS = cfl_pkg::NUM_TAPS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: sample_re, sample_im, tap_index, tap_value (lowest first), zero padded
    input  wire logic [cfl_pkg::IN_DATA_W-1:0] s_tdata,
    // tuser: func
    input  wire logic [cfl_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output cfl_pkg::item_t                     q_item
);
    import cfl_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            queue_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg,  count_next;
    item_t            dec_item;
    logic             dec_keep;
    logic             push, pop;

    always_comb begin
        dec_item.re    = s_tdata[SAMPLE_W-1:0];
        dec_item.im    = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        dec_item.idx   = s_tdata[2*SAMPLE_W+TAP_IDX_W-1:2*SAMPLE_W];
        dec_item.coeff = s_tdata[IN_FIELDS_W-1:2*SAMPLE_W+TAP_IDX_W];
        dec_item.kind  = KIND_SAMPLE;
        dec_keep       = 1'b0;
        unique case (s_tuser)
            FUNC_SAMPLE: begin
                dec_item.kind = KIND_SAMPLE;
                dec_keep      = 1'b1;
            end
            FUNC_COEFF: begin
                dec_item.kind = KIND_COEFF;
                dec_keep      = ({1'b0, dec_item.idx} < (TAP_IDX_W + 1)'(NUM_TAPS));
            end
            FUNC_END: begin
                dec_item.kind = KIND_END;
                dec_keep      = 1'b1;
            end
            default: begin
                dec_keep      = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != QCW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && dec_keep;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cfl_mac.sv -----
// MAC engine: delay line and coefficient memories, tap loop, rounding and output word.
`default_nettype none

module cfl_mac #(
    parameter int NUM_TAPS = cfl_pkg::NUM_TAPS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire cfl_pkg::item_t                 q_item,
    input  wire logic [cfl_pkg::SHIFT_W-1:0]    out_shift,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: out_re, out_im (lowest first)
    output logic [cfl_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // tuser: saturated
    output logic                                m_tuser
);
    import cfl_pkg::*;

    localparam int AW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int FW    = $clog2(NUM_TAPS + 1);
    localparam int PW    = SAMPLE_W + COEFF_W;
    localparam int ACC_W = PW + $clog2(NUM_TAPS) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [AW-1:0]               tap_reg, tap_next;
    logic [NUM_TAPS-1:0]         cvld_reg;

    logic [2*SAMPLE_W-1:0]       delay_mem [NUM_TAPS];
    logic signed [COEFF_W-1:0]   coeff_mem [NUM_TAPS];

    logic                        dl_we, cf_we, issue;
    logic [AW-1:0]               rd_pos;
    logic                        rd_dvld;

    logic [2*SAMPLE_W-1:0]       rd_d_reg;
    logic signed [COEFF_W-1:0]   rd_c_reg;
    logic                        rd_vld_reg;
    logic                        v1_reg, v2_reg;
    logic signed [PW-1:0]        prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]     acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]     rnd;
    logic signed [ACC_W-1:0]     sh_re, sh_im;
    logic signed [SAMPLE_W-1:0]  sat_re, sat_im;
    logic                        clip_re, clip_im;

    logic                        mv_reg;
    logic [OUT_DATA_W-1:0]       mdata_reg;
    logic                        mlast_reg, muser_reg;
    logic                        out_free;
    logic                        load_end, load_fir;

    assign out_free = !mv_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign dl_we    = q_valid && q_ready && (q_item.kind == KIND_SAMPLE);
    assign cf_we    = q_valid && q_ready && (q_item.kind == KIND_COEFF);
    assign load_end = q_valid && q_ready && (q_item.kind == KIND_END);
    assign load_fir = (state_reg == ST_OUT) && out_free;
    assign issue    = (state_reg == ST_MAC);

    assign rd_pos  = (wp_reg >= tap_reg) ? wp_reg - tap_reg
                                         : AW'(NUM_TAPS) + wp_reg - tap_reg;
    assign rd_dvld = ({1'b0, rd_pos} < (AW + 1)'(fill_reg));

    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (dl_we) begin
                    tap_next   = '0;
                    state_next = ST_MAC;
                    if (fill_reg != FW'(NUM_TAPS)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_MAC: begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == AW'(NUM_TAPS - 1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    wp_next    = (wp_reg == AW'(NUM_TAPS - 1)) ? '0 : wp_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            tap_reg   <= '0;
            cvld_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            tap_reg   <= tap_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (cf_we) begin
                cvld_reg[q_item.idx[AW-1:0]] <= 1'b1;
            end
            if (load_end || load_fir) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dl_we) begin
            delay_mem[wp_reg] <= {q_item.im, q_item.re};
        end
        rd_d_reg <= delay_mem[rd_pos];
    end

    always_ff @(posedge aclk) begin
        if (cf_we) begin
            coeff_mem[q_item.idx[AW-1:0]] <= q_item.coeff;
        end
        rd_c_reg <= coeff_mem[tap_reg];
    end

    // pipeline: read -> multiply -> accumulate
    always_ff @(posedge aclk) begin
        rd_vld_reg <= rd_dvld && cvld_reg[tap_reg];
        if (rd_vld_reg) begin
            prod_re_reg <= rd_c_reg * $signed(rd_d_reg[SAMPLE_W-1:0]);
            prod_im_reg <= rd_c_reg * $signed(rd_d_reg[2*SAMPLE_W-1:SAMPLE_W]);
        end else begin
            prod_re_reg <= '0;
            prod_im_reg <= '0;
        end
        if (dl_we) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (v2_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
        end else if (state_reg == ST_ROUND) begin
            acc_re_reg <= acc_re_reg + rnd;
            acc_im_reg <= acc_im_reg + rnd;
        end
    end

    assign rnd = (out_shift == '0) ? '0 : (ACC_W'(1) << (out_shift - 1'b1));

    always_comb begin
        sh_re   = acc_re_reg >>> out_shift;
        sh_im   = acc_im_reg >>> out_shift;
        clip_re = 1'b0;
        clip_im = 1'b0;
        sat_re  = sh_re[SAMPLE_W-1:0];
        sat_im  = sh_im[SAMPLE_W-1:0];
        if (sh_re > SAT_HI) begin
            sat_re  = SAT_HI[SAMPLE_W-1:0];
            clip_re = 1'b1;
        end else if (sh_re < SAT_LO) begin
            sat_re  = SAT_LO[SAMPLE_W-1:0];
            clip_re = 1'b1;
        end
        if (sh_im > SAT_HI) begin
            sat_im  = SAT_HI[SAMPLE_W-1:0];
            clip_im = 1'b1;
        end else if (sh_im < SAT_LO) begin
            sat_im  = SAT_LO[SAMPLE_W-1:0];
            clip_im = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_end) begin
            mdata_reg <= '0;
            mlast_reg <= 1'b1;
            muser_reg <= 1'b0;
        end else if (load_fir) begin
            mdata_reg <= OUT_DATA_W'({sat_im, sat_re});
            mlast_reg <= 1'b0;
            muser_reg <= clip_re || clip_im;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

`default_nettype wire

// ----- hdl/complex_fir_lowpass.sv -----
// Complex FIR low-pass filter top level: shift register, front queue and MAC engine.
// Sample word: one tap per cycle through the MAC engine, then flush and rounding steps; the
//   result then loads the output register. A new sample enters once the engine is idle
//   and the output register is free. Coefficient word: table entry written when the engine
//   takes it from the queue, no result. End word: goes straight to the output register.
// Reset (aresetn low, synchronous): delay line, coefficients and write pointer read as
//   zero through a fill count and per-entry valid bits; output_shift returns to 17.
`default_nettype none

module complex_fir_lowpass #(
    parameter int NUM_TAPS = cfl_pkg::NUM_TAPS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: sample_re, sample_im, tap_index, tap_value (lowest first), zero padded
    input  wire logic [cfl_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: func
    input  wire logic [cfl_pkg::FUNC_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: out_re, out_im (lowest first)
    output logic [cfl_pkg::OUT_DATA_W-1:0]      m_tdata,
    // tlast: is_end
    output logic                                m_tlast,
    // tuser: saturated
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cfl_pkg::SHIFT_W-1:0]    cfg_data
);
    import cfl_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;
    logic               q_valid, q_ready;
    item_t              q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            shift_reg <= cfg_data;
        end
    end

    cfl_front #(
        .NUM_TAPS (NUM_TAPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cfl_mac #(
        .NUM_TAPS (NUM_TAPS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_shift (shift_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hdl/cfl_checker.sv -----
// Port-level checks for the complex FIR low-pass filter, bound to the top level.
`default_nettype none

module cfl_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cfl_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);
    import cfl_pkg::*;

    logic re_rail, im_rail;

    assign re_rail = (m_tdata[SAMPLE_W-1:0] == {1'b0, {(SAMPLE_W-1){1'b1}}})
                  || (m_tdata[SAMPLE_W-1:0] == {1'b1, {(SAMPLE_W-1){1'b0}}});
    assign im_rail = (m_tdata[2*SAMPLE_W-1:SAMPLE_W] == {1'b0, {(SAMPLE_W-1){1'b1}}})
                  || (m_tdata[2*SAMPLE_W-1:SAMPLE_W] == {1'b1, {(SAMPLE_W-1){1'b0}}});

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata == '0) && !m_tuser)
        else $error("end word carries data or saturation flag");

    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> re_rail || im_rail)
        else $error("saturation flag without a clipped part");

endmodule

bind complex_fir_lowpass cfl_checker u_cfl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
